/* src/ordered_unique_list_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ordered unique list engine
// Shared immediate-implication and next-cycle checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ORDERED_UNIQUE_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_UNIQUE_LIST_ENGINE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define OULS_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ouls check failed");

// Check that cons holds in the cycle after ante
`define OULS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ouls check failed");

`endif

/* src/ouls_pkg.sv */
// ----------------------------------------------------------------------------
// ouls_pkg
// Widths, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package ouls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int ST_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND       = 3'd0,
    CMD_REMOVE_FRONT = 3'd1,
    CMD_INSERT_AT    = 3'd2,
    CMD_REMOVE_AT    = 3'd3,
    CMD_SEARCH       = 3'd4,
    CMD_READ_AT      = 3'd5
  } cmd_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_BAD_POS   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic commit;  // apply the command and load the result register
  } ouls_cmd_t;

endpackage

/* src/ouls_in_if.sv */
// ----------------------------------------------------------------------------
// ouls_in_if
// Command channel: valid/ready handshake with command, position and value.
// ----------------------------------------------------------------------------
interface ouls_in_if;
  import ouls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

/* src/ouls_out_if.sv */
// ----------------------------------------------------------------------------
// ouls_out_if
// Result channel: valid/ready handshake with status, data and counts.
// ----------------------------------------------------------------------------
interface ouls_out_if;
  import ouls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [WORD_W-1:0] data_out;
  logic [POS_W-1:0]         found_position;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, status, data_out, found_position, entry_count, input ready);
  modport sink   (input valid, status, data_out, found_position, entry_count, output ready);
endinterface

/* src/ouls_ctrl.sv */
// ----------------------------------------------------------------------------
// ouls_ctrl
// Two-state sequencer: capture a transaction, then commit it once the result
// register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
`include "ordered_unique_list_engine_top_defines.svh"

module ouls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ouls_pkg::ouls_cmd_t cmd
);
  import ouls_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t state;

  // Accept only while idle; commit when the result register drains
  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.commit = (state == S_EVAL) && (!out_valid || out_ready);

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (cmd.commit) state <= S_IDLE;
        end
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `OULS_ASSERT_NOW(a_load_commit_excl, clk, rst, cmd.load, !cmd.commit)
  `OULS_ASSERT_NOW(a_commit_room, clk, rst, cmd.commit, !out_valid || out_ready)
  `OULS_ASSERT_NEXT(a_load_to_eval, clk, rst, cmd.load, state == S_EVAL)

endmodule

/* src/ouls_datapath.sv */
// ----------------------------------------------------------------------------
// ouls_datapath
// Entry cells with per-entry comparators and shift muxes, the valid count,
// the captured transaction and the result register.
// ----------------------------------------------------------------------------
`include "ordered_unique_list_engine_top_defines.svh"

module ouls_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ouls_pkg::ouls_cmd_t           cmd,
  input  logic [ouls_pkg::CMD_W-1:0]    command,
  input  logic [ouls_pkg::POS_W-1:0]    position,
  input  logic signed [ouls_pkg::WORD_W-1:0] value,
  output logic [ouls_pkg::ST_W-1:0]     status,
  output logic signed [ouls_pkg::WORD_W-1:0] data_out,
  output logic [ouls_pkg::POS_W-1:0]    found_position,
  output logic [ouls_pkg::CNT_W-1:0]    entry_count
);
  import ouls_pkg::*;

  // Captured transaction
  logic [CMD_W-1:0]  cmd_q;
  logic [IDX_W-1:0]  pos_q;
  logic [WORD_W-1:0] val_q;

  // List state
  logic [WORD_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Result register
  status_t           res_status;
  logic [WORD_W-1:0] res_data;
  logic [IDX_W-1:0]  res_found;
  logic [CNT_W-1:0]  res_count;

  // Decision signals
  logic [CAPACITY-1:0] match;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                full;
  logic                empty;
  logic [CNT_W-1:0]    pos_ext;
  logic [IDX_W-1:0]    rd_pos;
  logic [WORD_W-1:0]   rd_word;
  status_t             st;
  logic [WORD_W-1:0]   dat;
  logic [IDX_W-1:0]    fnd;
  logic                ins_en;
  logic                rm_en;
  logic [IDX_W-1:0]    ins_pos;
  logic [IDX_W-1:0]    rm_pos;

  logic [CAPACITY-1:0] cell_we;
  logic [WORD_W-1:0]   cell_next [CAPACITY];

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= $unsigned(value);
    end
  end

  // Compare every valid entry against the captured value
  for (genvar g = 0; g < CAPACITY; g++) begin : g_match
    assign match[g] = (entries[g] == val_q) && (CNT_W'(g) < count);
  end

  // Pick the lowest matching position
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_ext = CNT_W'(pos_q);
  assign rd_pos  = (cmd_q == CMD_REMOVE_FRONT) ? '0 : pos_q;
  assign rd_word = entries[rd_pos];

  // Decide status, result and list update
  always_comb begin
    st      = ST_OK;
    dat     = '0;
    fnd     = '0;
    ins_en  = 1'b0;
    rm_en   = 1'b0;
    ins_pos = pos_q;
    rm_pos  = rd_pos;
    unique case (cmd_q)
      CMD_APPEND: begin
        ins_pos = count[IDX_W-1:0];
        if (full)     st = ST_FULL;
        else if (hit) st = ST_DUPLICATE;
        else          ins_en = 1'b1;
      end
      CMD_INSERT_AT: begin
        if (full)                 st = ST_FULL;
        else if (pos_ext > count) st = ST_BAD_POS;
        else if (hit)             st = ST_DUPLICATE;
        else                      ins_en = 1'b1;
      end
      CMD_REMOVE_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rm_en = 1'b1;
          dat   = rd_word;
        end
      end
      CMD_REMOVE_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= count) begin
          st = ST_BAD_POS;
        end else begin
          rm_en = 1'b1;
          dat   = rd_word;
        end
      end
      CMD_SEARCH: begin
        if (hit) fnd = hit_idx;
        else     st  = ST_NOT_FOUND;
      end
      CMD_READ_AT: begin
        if (pos_ext >= count) st  = ST_BAD_POS;
        else                  dat = rd_word;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Per-cell shift select: load, take from below (insert) or from above (remove)
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    logic              ins_here;
    logic              ins_shift;
    logic              rm_shift;

    if (g > 0) begin : g_lo
      assign lower = entries[g-1];
    end else begin : g_lo0
      assign lower = '0;
    end
    if (g < CAPACITY - 1) begin : g_up
      assign upper = entries[g+1];
    end else begin : g_up0
      assign upper = '0;
    end

    assign ins_here  = ins_en && (IDX_W'(g) == ins_pos);
    assign ins_shift = ins_en && (IDX_W'(g) > ins_pos) && (CNT_W'(g) <= count);
    assign rm_shift  = rm_en && (IDX_W'(g) >= rm_pos) && (CNT_W'(g + 1) < count);

    assign cell_we[g]   = ins_here || ins_shift || rm_shift;
    assign cell_next[g] = ins_here ? val_q : (ins_shift ? lower : upper);
  end

  // Write the cells
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.commit && cell_we[i]) entries[i] <= cell_next[i];
    end
  end

  // Advance the valid count
  always_comb begin
    count_next = count;
    if (ins_en)     count_next = count + 1'b1;
    else if (rm_en) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status <= st;
      res_data   <= dat;
      res_found  <= fnd;
      res_count  <= count_next;
    end
  end

  assign status         = res_status;
  assign data_out       = $signed(res_data);
  assign found_position = POS_W'(res_found);
  assign entry_count    = res_count;

  `OULS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `OULS_ASSERT_NEXT(a_result_count, clk, rst, cmd.commit, res_count == count)
  `OULS_ASSERT_NEXT(a_insert_grows, clk, rst, cmd.commit && ins_en, count == $past(count) + 1'b1)

endmodule

/* src/ordered_unique_list_engine_top.sv */
// ----------------------------------------------------------------------------
// ordered_unique_list_engine_top
// Fixed-capacity positional list of unique signed words with append, insert,
// remove, search and read commands; one result per command.
// ----------------------------------------------------------------------------
// Each command transaction is captured in its accept cycle; in the evaluation
// state the engine compares the value against every valid entry at once,
// shifts the entry cells and loads the result register, and only then returns
// to accept the next command. A waiting result does not block acceptance,
// but the following command waits in its evaluation state until that result
// is taken. The list holds 16 entries and is empty after reset, with no
// clearing pass; unused command codes report ok and change nothing.
module ordered_unique_list_engine_top (
  input logic        clk,
  input logic        rst,
  ouls_in_if.sink    cmd_ch,
  ouls_out_if.source rsp_ch
);
  import ouls_pkg::*;

  ouls_cmd_t cmd;

  ouls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (rsp_ch.valid),
    .out_ready (rsp_ch.ready),
    .cmd       (cmd)
  );

  ouls_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .command        (cmd_ch.command),
    .position       (cmd_ch.position),
    .value          (cmd_ch.value),
    .status         (rsp_ch.status),
    .data_out       (rsp_ch.data_out),
    .found_position (rsp_ch.found_position),
    .entry_count    (rsp_ch.entry_count)
  );

endmodule

/* tb/list_checker.sv */
// ----------------------------------------------------------------------------
// list_checker
// Watches the command and result channels of the list engine, keeps its own
// copy of the list, predicts the result of every accepted command and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module list_checker (
  input  logic clk,
  input  logic rst,
  ouls_in_if   cmd_mon,
  ouls_out_if  rsp_mon,
  output int   fail_count,
  output int   pending
);
  import ouls_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] data;
    logic [POS_W-1:0]         found;
    logic [CNT_W-1:0]         count;
  } list_result_t;

  // Shadow copy of the list
  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int                       list_size;

  list_result_t             expected_results [$];
  int                       failures = 0;

  // Return the position of a word among the valid entries, or -1
  function automatic int find_word(logic signed [WORD_W-1:0] word);
    for (int i = 0; i < list_size; i++) begin
      if (list_words[i] == word) return i;
    end
    return -1;
  endfunction

  // Drop one entry and shift the later entries down
  function automatic void close_gap(int at);
    for (int i = at; i + 1 < list_size; i++) begin
      list_words[i] = list_words[i + 1];
    end
    list_size--;
  endfunction

  // Apply one command to the shadow list and return its result
  function automatic list_result_t apply_command(logic [CMD_W-1:0] op,
                                                 logic [POS_W-1:0] pos,
                                                 logic signed [WORD_W-1:0] word);
    list_result_t res;
    int           hit;
    res        = '0;
    res.status = ST_OK;
    case (op)
      CMD_APPEND: begin
        if (list_size >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (find_word(word) >= 0) begin
          res.status = ST_DUPLICATE;
        end else begin
          list_words[list_size] = word;
          list_size++;
        end
      end
      CMD_REMOVE_FRONT: begin
        if (list_size == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = list_words[0];
          close_gap(0);
        end
      end
      CMD_INSERT_AT: begin
        if (list_size >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (int'(pos) > list_size) begin
          res.status = ST_BAD_POS;
        end else if (find_word(word) >= 0) begin
          res.status = ST_DUPLICATE;
        end else begin
          for (int i = list_size; i > int'(pos); i--) begin
            list_words[i] = list_words[i - 1];
          end
          list_words[pos] = word;
          list_size++;
        end
      end
      CMD_REMOVE_AT: begin
        if (list_size == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(pos) >= list_size) begin
          res.status = ST_BAD_POS;
        end else begin
          res.data = list_words[pos];
          close_gap(int'(pos));
        end
      end
      CMD_SEARCH: begin
        hit = find_word(word);
        if (hit >= 0) begin
          res.found = hit[POS_W-1:0];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      CMD_READ_AT: begin
        if (int'(pos) >= list_size) begin
          res.status = ST_BAD_POS;
        end else begin
          res.data = list_words[pos];
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.count = list_size[CNT_W-1:0];
    return res;
  endfunction

  // Report one field that differs from its prediction
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // Compare results first, then predict the command taken at the same edge
  always @(posedge clk) begin : track
    list_result_t want;
    if (rst) begin
      list_size = 0;
      expected_results.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no command waiting, expected none, actual status %0d",
                   $time, rsp_mon.status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, rsp_mon.status);
          check_field("data_out", want.data, rsp_mon.data_out);
          check_field("found_position", want.found, rsp_mon.found_position);
          check_field("entry_count", want.count, rsp_mon.entry_count);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_results.push_back(apply_command(cmd_mon.command, cmd_mon.position,
                                                 cmd_mon.value));
      end
    end
    pending    <= expected_results.size();
    fail_count <= failures;
  end

  // Flag predictions never matched by a result
  final begin
    if (expected_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_results.size());
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives command transactions into the list engine with random gaps and
// result back-pressure: a directed pass over the corner cases, then random
// traffic in grow, shrink and mixed segments. The checker predicts and
// compares; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ouls_pkg::*;

  localparam logic [CMD_W-1:0]         CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0]         CMD_SPARE_7 = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MIN    = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX    = 32'sh7fff_ffff;
  localparam int POOL_SIZE      = 28;
  localparam int SEGMENTS       = 25;
  localparam int SEGMENT_ITEMS  = 26;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} traffic_mix_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_req;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  logic signed [WORD_W-1:0] word_pool [POOL_SIZE];

  ouls_in_if  cmd_ch ();
  ouls_out_if rsp_ch ();

  ordered_unique_list_engine_top dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .rsp_ch (rsp_ch)
  );

  list_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .cmd_mon    (cmd_ch),
    .rsp_mon    (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 35) return CMD_APPEND;
        if (r < 70) return CMD_INSERT_AT;
        if (r < 80) return CMD_SEARCH;
        if (r < 90) return CMD_READ_AT;
        if (r < 95) return CMD_REMOVE_AT;
        return CMD_REMOVE_FRONT;
      end
      MIX_SHRINK: begin
        if (r < 30) return CMD_REMOVE_FRONT;
        if (r < 60) return CMD_REMOVE_AT;
        if (r < 70) return CMD_APPEND;
        if (r < 80) return CMD_INSERT_AT;
        if (r < 90) return CMD_SEARCH;
        return CMD_READ_AT;
      end
      default: return CMD_W'($urandom_range(0, (1 << CMD_W) - 1));
    endcase
  endfunction

  // Favor low positions so inserts and removes land inside the list
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 3));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Draw from a small pool so duplicates and search hits are common
  function automatic logic signed [WORD_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 80) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Offer one command, hold it until accepted, then idle for a gap
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [WORD_W-1:0] word, input bit steady);
    int gap;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= op;
    cmd_ch.position <= pos;
    cmd_ch.value    <= word;
    do @(posedge clk); while (!cmd_ch.ready);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    traffic_mix_t mix;
    bit           steady;
    rst             <= 1'b1;
    hold_req        <= 1'b0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.command  <= CMD_APPEND;
    cmd_ch.position <= '0;
    cmd_ch.value    <= '0;
    word_pool[0] = WORD_MIN;
    word_pool[1] = WORD_MAX;
    word_pool[2] = '0;
    word_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) word_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list cases
    send_command(CMD_SEARCH, 0, 0, 0);
    send_command(CMD_READ_AT, 0, 0, 0);
    send_command(CMD_REMOVE_FRONT, 0, 0, 0);
    send_command(CMD_REMOVE_AT, 15, 0, 0);
    send_command(CMD_INSERT_AT, 1, 5, 0);
    // Build a short list, hitting duplicates and bad insert positions
    send_command(CMD_INSERT_AT, 0, WORD_MIN, 0);
    send_command(CMD_APPEND, 15, WORD_MAX, 0);
    send_command(CMD_APPEND, 15, WORD_MIN, 0);
    send_command(CMD_INSERT_AT, 2, 0, 0);
    send_command(CMD_INSERT_AT, 1, -1, 0);
    send_command(CMD_INSERT_AT, 0, WORD_MAX, 0);
    send_command(CMD_INSERT_AT, 5, 7, 0);
    send_command(CMD_INSERT_AT, 15, 7, 0);
    // Search, read and remove at and past the end
    send_command(CMD_SEARCH, 0, WORD_MAX, 0);
    send_command(CMD_SEARCH, 0, 12345, 0);
    send_command(CMD_READ_AT, 3, 0, 0);
    send_command(CMD_READ_AT, 4, 0, 0);
    send_command(CMD_REMOVE_AT, 4, 0, 0);
    send_command(CMD_REMOVE_AT, 1, 0, 0);
    send_command(CMD_REMOVE_FRONT, 0, 0, 0);
    send_command(CMD_SPARE_6, 15, -1, 0);
    send_command(CMD_SPARE_7, 15, WORD_MAX, 0);
    send_command(CMD_REMOVE_AT, 1, 0, 0);
    send_command(CMD_REMOVE_FRONT, 0, 0, 0);
    send_command(CMD_SEARCH, 0, WORD_MIN, 0);
    wait_for_drain();

    // Random traffic in segments
    for (int s = 0; s < SEGMENTS; s++) begin
      mix    = traffic_mix_t'($urandom_range(0, 2));
      steady = ($urandom_range(0, 3) == 0);
      if (s == SEGMENTS / 2) begin
        // Starve the result side and keep offering so the engine backs up
        hold_req <= 1'b1;
        steady = 1'b1;
      end
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        send_command(pick_command(mix), pick_position(), pick_value(), steady);
      end
      if (s == SEGMENTS / 4) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: streaks of ready and stalls, plus one long hold on request
  initial begin : result_sink
    int  hold_left;
    int  open_left;
    bit  hold_served;
    hold_left   = 0;
    open_left   = 0;
    hold_served = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = LONG_HOLD;
        open_left   = 1;
      end else if (hold_left == 0 && open_left == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          hold_left = 0;
          open_left = $urandom_range(40, 80);
        end else begin
          hold_left = pick_gap();
          open_left = $urandom_range(1, 24);
        end
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        open_left--;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

/* ordered_unique_list_engine_top.f */
+incdir+src
src/ouls_pkg.sv
src/ouls_in_if.sv
src/ouls_out_if.sv
src/ouls_ctrl.sv
src/ouls_datapath.sv
src/ordered_unique_list_engine_top.sv
tb/list_checker.sv
tb/testbench.sv
